[design/fpfl_pkg.sv]
// ----------------------------------------------------------------------------
// fpfl_pkg
// Types and constants shared by the fixed-size pool allocator modules.
// ----------------------------------------------------------------------------
package fpfl_pkg;

    localparam int COUNT_W  = 11;
    localparam int SIZE_W   = 13;
    localparam int IDX_W    = 10;
    localparam int OFFSET_W = 23;
    localparam int STRIDE_W = 14;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd64;

    // Request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OOM      = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

    // Register indexes
    localparam logic REG_CHUNK_COUNT = 1'b0;
    localparam logic REG_CHUNK_SIZE  = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    chunk_index;
        logic [OFFSET_W-1:0] byte_offset;
    } rsp_t;

    typedef struct packed {
        logic latch;   // capture request, start link read
        logic commit;  // update pool state, load result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;  // result register can take a new result
    } dp_stat_t;

endpackage

[design/fpfl_ctrl.sv]
// ----------------------------------------------------------------------------
// fpfl_ctrl
// Two-state sequencer: accept a request, then commit it once the result
// register has room.
// ----------------------------------------------------------------------------
module fpfl_ctrl
    import fpfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/fpfl_dp.sv]
// ----------------------------------------------------------------------------
// fpfl_dp
// Pool state, next-link memory, offset arithmetic and result register.
// ----------------------------------------------------------------------------
module fpfl_dp
    import fpfl_pkg::*;
#(
    parameter int MAX_CHUNKS   = 1024,
    parameter int HEADER_BYTES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    input  req_t               req,
    input  logic [COUNT_W-1:0] chunk_count,
    input  logic [SIZE_W-1:0]  chunk_size,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp
);

    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int MW = $clog2(MAX_CHUNKS + 1);
    localparam int CW = (MW > COUNT_W) ? MW : COUNT_W;
    localparam int PW = (IW + STRIDE_W + 1 > OFFSET_W) ? IW + STRIDE_W + 1 : OFFSET_W;
    localparam logic [MW-1:0] LINK_END  = MW'(MAX_CHUNKS);
    localparam logic [CW-1:0] MAX_CMP   = CW'(MAX_CHUNKS);

    logic [MW-1:0] link_mem [MAX_CHUNKS];

    logic [IW-1:0] head_reg, head_next;
    logic          nonempty_reg, nonempty_next;
    logic [MW-1:0] mark_reg, mark_next;
    logic [MW-1:0] rd_link_reg;
    req_t          req_reg;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [CW-1:0] mark_ext, count_ext, live, fidx_ext, idx_ext;
    logic [IW-1:0] alloc_idx, fidx;
    logic          got, link_we;
    logic [MW-1:0] link_wdata;
    logic [STRIDE_W-1:0] stride;
    logic [PW-1:0] off_full;

    assign mark_ext  = CW'(mark_reg);
    assign count_ext = CW'(chunk_count);
    assign live      = (count_ext > MAX_CMP) ? MAX_CMP : count_ext;
    assign fidx_ext  = CW'(req_reg.free_index);
    assign fidx      = fidx_ext[IW-1:0];
    assign stride    = STRIDE_W'(chunk_size) + STRIDE_W'(HEADER_BYTES);
    assign idx_ext   = CW'(alloc_idx);
    assign off_full  = PW'(alloc_idx) * PW'(stride) + PW'(HEADER_BYTES);
    assign link_wdata = nonempty_reg ? MW'(head_reg) : LINK_END;

    assign stat.slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        mark_next     = mark_reg;
        alloc_idx     = '0;
        got           = 1'b0;
        link_we       = 1'b0;
        rsp_next      = '0;
        if (cmd.commit)
        begin
            unique case (req_reg.req_type)
                REQ_ALLOC:
                begin
                    if (nonempty_reg)
                    begin
                        alloc_idx = head_reg;
                        got       = 1'b1;
                        if (rd_link_reg == LINK_END)
                        begin
                            nonempty_next = 1'b0;
                            head_next     = '0;
                        end
                        else
                        begin
                            head_next = rd_link_reg[IW-1:0];
                        end
                    end
                    else if (mark_ext < live)
                    begin
                        alloc_idx = mark_reg[IW-1:0];
                        got       = 1'b1;
                        mark_next = mark_reg + 1'b1;
                    end
                    if (got)
                    begin
                        rsp_next.status      = STAT_OK;
                        rsp_next.chunk_index = idx_ext[IDX_W-1:0];
                        rsp_next.byte_offset = off_full[OFFSET_W-1:0];
                    end
                    else
                    begin
                        rsp_next.status = STAT_OOM;
                    end
                end
                REQ_FREE:
                begin
                    if (fidx_ext >= mark_ext || fidx_ext >= MAX_CMP)
                    begin
                        rsp_next.status = STAT_BAD_FREE;
                    end
                    else
                    begin
                        link_we       = 1'b1;
                        head_next     = fidx;
                        nonempty_next = 1'b1;
                    end
                end
                REQ_INIT:
                begin
                    head_next     = '0;
                    nonempty_next = 1'b0;
                    mark_next     = '0;
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // link memory: one write port (free), one registered read port (head)
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[fidx] <= link_wdata;
        end
        if (cmd.latch)
        begin
            rd_link_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            mark_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            mark_reg      <= mark_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/fixed_pool_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator
// Fixed-size chunk pool allocator with a LIFO free list and lazy watermark.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_ready, payload req): alloc, free or init.
//    Every request transaction yields exactly one response transaction
//    (rsp_valid/rsp_ready, payload rsp) carrying status, chunk index and
//    payload byte offset.
//  - The accept cycle of a request issues the read of the head chunk's next
//    link from the link memory; the execute cycle then uses the registered
//    read data to pop the list, computes the offset with one multiply-add and
//    loads the response register, waiting first while that register is full.
//    A new request is taken only after the previous one has committed.
//  - The response register sits between the two sides, so a new request is
//    accepted while the previous response still waits. If the receiver stalls,
//    the second request holds in its execute cycle until the response
//    register frees up, and req_ready stays low meanwhile.
//  - Reset empties the pool (empty list, watermark 0) and sets chunk_count to
//    1024 and chunk_size to 64. The link memory needs no clearing: only
//    entries written by a free are ever used.
//  - APB registers: 0x0 chunk_count, 0x4 chunk_size. Write only while idle.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator
    import fpfl_pkg::*;
#(
    parameter int MAX_CHUNKS   = 1024,
    parameter int HEADER_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    logic [COUNT_W-1:0] count_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               cfg_wr;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;

    // APB: zero wait states, register index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            size_reg  <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CHUNK_COUNT)
            begin
                count_reg <= pwdata[COUNT_W-1:0];
            end
            else
            begin
                size_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CHUNK_COUNT) ? 32'(count_reg) : 32'(size_reg);

    // sequencer: accept, then commit when the response register has room
    fpfl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // pool state, link memory, offset math, response register
    fpfl_dp
    #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req         (req),
        .chunk_count (count_reg),
        .chunk_size  (size_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    // a transaction is followed by its execute cycle, never a second accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted in execute cycle");

    // a commit always leaves a response pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("committed response not presented");

    // commit only when the response register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid || rsp_ready))
        else $error("response overwritten while stalled");

    // failed requests carry no chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STAT_OK) |-> (rsp.chunk_index == '0 && rsp.byte_offset == '0))
        else $error("error response with nonzero chunk fields");

endmodule
